[rtl/rkc_pkg.sv]
// Shared types and constants for the RGB kernel convolution engine.
`timescale 1ns / 1ps
`default_nettype none

package rkc_pkg;

	localparam int COEF_W  = 24;
	localparam int PIX_W   = 8;
	localparam int ACC_W   = 40;
	localparam int PROD_W  = COEF_W + PIX_W + 1;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	localparam logic CMD_COEF = 1'b0;
	localparam logic CMD_TAP  = 1'b1;

	// Control travelling alongside a window tap through the pipe.
	typedef struct packed {
		logic valid;
		logic last;
	} tap_ctl_t;

endpackage

`default_nettype wire

[rtl/rkc_kernel_mem.sv]
// Kernel coefficient store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rkc_kernel_mem #(
	parameter int DEPTH = 81,
	parameter int AW    = 7
) (
	input  wire                              clk,
	input  wire                              wr_en,
	input  wire [AW-1:0]                     wr_addr,
	input  wire signed [rkc_pkg::COEF_W-1:0] wr_data,
	input  wire                              rd_en,
	input  wire [AW-1:0]                     rd_addr,
	output logic signed [rkc_pkg::COEF_W-1:0] rd_data
);

	logic signed [rkc_pkg::COEF_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/rkc_mac.sv]
// One colour channel: multiply, accumulate, and truncate/clamp on the last tap.
`timescale 1ns / 1ps
`default_nettype none

module rkc_mac #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              en,
	input  wire signed [rkc_pkg::COEF_W-1:0] coef_s1,
	input  wire [rkc_pkg::PIX_W-1:0]         pix_s1,
	input  wire rkc_pkg::tap_ctl_t           ctl_s2,
	output logic [rkc_pkg::PIX_W-1:0]        chan
);

	localparam int ACC_W = rkc_pkg::ACC_W;
	localparam int PROD_W = rkc_pkg::PROD_W;
	localparam int PIX_W = rkc_pkg::PIX_W;

	logic signed [PROD_W-1:0] prod_s2;
	logic [ACC_W-1:0]         sum_q;
	logic [ACC_W-1:0]         sum_nxt;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= coef_s1 * $signed({1'b0, pix_s1});
		end
	end

	assign sum_nxt = sum_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (en && ctl_s2.valid) begin
			sum_q <= ctl_s2.last ? '0 : sum_nxt;
		end
	end

	// floor of the Q format sum, negative -> 0, overflow -> 255
	always_comb begin
		if (sum_nxt[ACC_W-1]) begin
			chan = '0;
		end else if (|sum_nxt[ACC_W-2:COEF_FRAC_BITS+PIX_W]) begin
			chan = rkc_pkg::PIX_MAX;
		end else begin
			chan = sum_nxt[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
		end
	end

endmodule

`default_nettype wire

[rtl/rgb_kernel_convolution.sv]
// Top level of the RGB square-kernel convolution engine.
// A last tap passes the s1, s2 and output registers before its pixel reaches out_*.
// Throughput: one transaction per cycle when not stalled; one MAC per channel.
// The kernel store read is registered; a coefficient may be used from the next item.
// Reset (arst_n, asynchronous) clears accumulators and pipeline valids;
// kernel coefficients are not reset and must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module rgb_kernel_convolution #(
	parameter int MAX_TAPS       = 81,
	parameter int COEF_FRAC_BITS = 16,
	localparam int TAP_W         = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              command,
	input  wire [TAP_W-1:0]                  tap_index,
	input  wire signed [rkc_pkg::COEF_W-1:0] coefficient,
	input  wire [rkc_pkg::PIX_W-1:0]         tap_red,
	input  wire [rkc_pkg::PIX_W-1:0]         tap_green,
	input  wire [rkc_pkg::PIX_W-1:0]         tap_blue,
	input  wire [rkc_pkg::PIX_W-1:0]         center_alpha,
	input  wire                              last_tap,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [rkc_pkg::PIX_W-1:0]        out_red,
	output logic [rkc_pkg::PIX_W-1:0]        out_green,
	output logic [rkc_pkg::PIX_W-1:0]        out_blue,
	output logic [rkc_pkg::PIX_W-1:0]        out_alpha
);

	localparam int PIX_W = rkc_pkg::PIX_W;

	logic en;
	logic accept;
	logic idx_ok;

	rkc_pkg::tap_ctl_t ctl_s1, ctl_s2;
	logic              idx_ok_s1;
	logic [PIX_W-1:0]  red_s1, green_s1, blue_s1, alpha_s1, alpha_s2;
	logic signed [rkc_pkg::COEF_W-1:0] mem_rd;
	logic signed [rkc_pkg::COEF_W-1:0] coef_s1;
	logic [PIX_W-1:0]  red_c, green_c, blue_c;

	logic              out_valid_q;
	logic [PIX_W-1:0]  out_red_q, out_green_q, out_blue_q, out_alpha_q;

	// whole pipe holds only while a result is waiting and being refused
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;
	assign accept   = in_valid && en;
	assign idx_ok   = 32'(tap_index) < MAX_TAPS;

	rkc_kernel_mem #(
		.DEPTH (MAX_TAPS),
		.AW    (TAP_W)
	) u_kmem (
		.clk     (clk),
		.wr_en   (accept && (command == rkc_pkg::CMD_COEF) && idx_ok),
		.wr_addr (tap_index),
		.wr_data (coefficient),
		.rd_en   (accept && (command == rkc_pkg::CMD_TAP) && idx_ok),
		.rd_addr (tap_index),
		.rd_data (mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid && (command == rkc_pkg::CMD_TAP);
			ctl_s1.last  <= last_tap;
			ctl_s2       <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_ok_s1 <= idx_ok;
			red_s1    <= tap_red;
			green_s1  <= tap_green;
			blue_s1   <= tap_blue;
			alpha_s1  <= center_alpha;
			alpha_s2  <= alpha_s1;
		end
	end

	// out-of-range tap contributes nothing
	assign coef_s1 = idx_ok_s1 ? mem_rd : '0;

	rkc_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac_red (
		.clk(clk), .arst_n(arst_n), .en(en), .coef_s1(coef_s1),
		.pix_s1(red_s1), .ctl_s2(ctl_s2), .chan(red_c)
	);

	rkc_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac_green (
		.clk(clk), .arst_n(arst_n), .en(en), .coef_s1(coef_s1),
		.pix_s1(green_s1), .ctl_s2(ctl_s2), .chan(green_c)
	);

	rkc_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac_blue (
		.clk(clk), .arst_n(arst_n), .en(en), .coef_s1(coef_s1),
		.pix_s1(blue_s1), .ctl_s2(ctl_s2), .chan(blue_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	// zero centre alpha gives transparent black
	always_ff @(posedge clk) begin
		if (en && ctl_s2.valid && ctl_s2.last) begin
			if (alpha_s2 == '0) begin
				out_red_q   <= '0;
				out_green_q <= '0;
				out_blue_q  <= '0;
			end else begin
				out_red_q   <= red_c;
				out_green_q <= green_c;
				out_blue_q  <= blue_c;
			end
			out_alpha_q <= alpha_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;
	assign out_alpha = out_alpha_q;

endmodule

`default_nettype wire

[test/rgb_kernel_convolution_tb.sv]
// Self-checking testbench for the RGB kernel convolution engine.
`timescale 1ns / 1ps

module rgb_kernel_convolution_tb;

	localparam int PIX_W  = rkc_pkg::PIX_W;
	localparam int COEF_W = rkc_pkg::COEF_W;
	localparam int ACC_W  = rkc_pkg::ACC_W;
	localparam logic [PIX_W-1:0] PIX_MAX = rkc_pkg::PIX_MAX;
	localparam logic CMD_COEF = rkc_pkg::CMD_COEF;
	localparam logic CMD_TAP  = rkc_pkg::CMD_TAP;

	localparam int N_TAPS    = 81;
	localparam int FRAC      = 16;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] alpha;
	} rgba_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = CMD_COEF;
	logic [6:0] tap_index = '0;
	logic signed [COEF_W-1:0] coefficient = '0;
	logic [PIX_W-1:0] tap_red = '0;
	logic [PIX_W-1:0] tap_green = '0;
	logic [PIX_W-1:0] tap_blue = '0;
	logic [PIX_W-1:0] center_alpha = '0;
	logic last_tap = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_W-1:0] out_red;
	logic [PIX_W-1:0] out_green;
	logic [PIX_W-1:0] out_blue;
	logic [PIX_W-1:0] out_alpha;

	// Predictor state
	logic signed [COEF_W-1:0] kern_tbl [0:N_TAPS-1];
	bit coef_written [0:N_TAPS-1];
	logic [ACC_W-1:0] acc_r = '0;
	logic [ACC_W-1:0] acc_g = '0;
	logic [ACC_W-1:0] acc_b = '0;
	rgba_t pix_expected [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int pixels_checked = 0;
	int windows_run = 0;
	int errors = 0;
	int idle_cycles = 0;

	rgb_kernel_convolution DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.tap_index(tap_index),
		.coefficient(coefficient),
		.tap_red(tap_red),
		.tap_green(tap_green),
		.tap_blue(tap_blue),
		.center_alpha(center_alpha),
		.last_tap(last_tap),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.out_alpha(out_alpha)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic [PIX_W-1:0] clamp_channel(logic [ACC_W-1:0] acc);
		if (acc[ACC_W-1])
			return '0;
		if (acc[ACC_W-1:FRAC] > 255)
			return PIX_MAX;
		return acc[FRAC+PIX_W-1:FRAC];
	endfunction

	function automatic logic [ACC_W-1:0] mac(logic [ACC_W-1:0] acc,
			logic signed [COEF_W-1:0] c, logic [PIX_W-1:0] p);
		longint prod;
		prod = longint'(c) * longint'(p);
		return acc + prod[ACC_W-1:0];
	endfunction

	// Updates the predicted kernel and sums for one accepted transaction.
	task automatic convolve_predict(input logic cmd, input logic [6:0] idx,
			input logic signed [COEF_W-1:0] c, input logic [PIX_W-1:0] r, g, b, a,
			input logic is_last);
		logic signed [COEF_W-1:0] w;
		rgba_t px;
		items_sent++;
		if (cmd == CMD_COEF) begin
			if (idx < N_TAPS) begin
				kern_tbl[idx] = c;
				coef_written[idx] = 1'b1;
			end
			return;
		end
		w = (idx < N_TAPS) ? kern_tbl[idx] : '0;
		acc_r = mac(acc_r, w, r);
		acc_g = mac(acc_g, w, g);
		acc_b = mac(acc_b, w, b);
		if (!is_last)
			return;
		if (a == 0) begin
			px = '0;
		end else begin
			px.red = clamp_channel(acc_r);
			px.green = clamp_channel(acc_g);
			px.blue = clamp_channel(acc_b);
			px.alpha = a;
		end
		pix_expected.push_back(px);
		acc_r = '0;
		acc_g = '0;
		acc_b = '0;
	endtask

	task automatic send_item(input logic cmd, input logic [6:0] idx,
			input logic signed [COEF_W-1:0] c, input logic [PIX_W-1:0] r, g, b, a,
			input logic is_last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		tap_index <= idx;
		coefficient <= c;
		tap_red <= r;
		tap_green <= g;
		tap_blue <= b;
		center_alpha <= a;
		last_tap <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		convolve_predict(cmd, idx, c, r, g, b, a, is_last);
	endtask

	// Coefficient write; pixel fields carry noise
	task automatic write_coef(input logic [6:0] idx, input logic signed [COEF_W-1:0] c,
			input logic is_last);
		send_item(CMD_COEF, idx, c, PIX_W'($urandom), PIX_W'($urandom),
			PIX_W'($urandom), PIX_W'($urandom), is_last);
	endtask

	task automatic send_tap(input logic [6:0] idx, input logic [PIX_W-1:0] r, g, b, a,
			input logic is_last);
		send_item(CMD_TAP, idx, COEF_W'($urandom), r, g, b, a, is_last);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pix_expected.size() != 0)
			@(negedge clk);
	endtask

	// Result checker
	always @(posedge clk) begin
		rgba_t got;
		rgba_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_red, out_green, out_blue, out_alpha};
			if (pix_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d", $time,
					got.red, got.green, got.blue, got.alpha);
			end else begin
				want = pix_expected.pop_front();
				pixels_checked++;
				if (got !== want) begin
					errors++;
					$display({"%0t: pixel mismatch expected r=%0d g=%0d b=%0d a=%0d,",
						" actual r=%0d g=%0d b=%0d a=%0d"},
						$time, want.red, want.green, want.blue, want.alpha,
						got.red, got.green, got.blue, got.alpha);
				end
			end
		end
	end

	// Watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: watchdog expired, %0d pixels outstanding", $time,
					pix_expected.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic test_kernel_extremes();
		write_coef(7'd0, 24'sh800000, 1'b0);
		write_coef(7'd1, 24'sh7FFFFF, 1'b0);
		write_coef(7'd80, 24'sh010000, 1'b0);
		write_coef(7'd2, 24'shFFFFFF, 1'b0);
		send_tap(7'd1, 8'd255, 8'd0, 8'd1, 8'd255, 1'b1);
		send_tap(7'd0, 8'd255, 8'd1, 8'd0, 8'd1, 1'b1);
	endtask

	task automatic test_clamp_boundary();
		// exactly 255.0, 254.0 and -1 lsb
		send_tap(7'd80, 8'd255, 8'd254, 8'd0, 8'd0, 1'b0);
		send_tap(7'd2, 8'd0, 8'd0, 8'd1, 8'd128, 1'b1);
		// one lsb under 255.0
		send_tap(7'd80, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
		send_tap(7'd2, 8'd1, 8'd0, 8'd255, 8'd200, 1'b1);
	endtask

	task automatic test_zero_alpha();
		send_tap(7'd80, 8'd200, 8'd100, 8'd50, 8'd0, 1'b1);
		// sums must have been cleared
		send_tap(7'd80, 8'd7, 8'd8, 8'd9, 8'd9, 1'b1);
	endtask

	task automatic test_out_of_range();
		write_coef(7'd81, 24'sh7FFFFF, 1'b0);
		write_coef(7'd127, 24'sh123456, 1'b0);
		send_tap(7'd127, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		send_tap(7'd81, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		send_tap(7'd80, 8'd10, 8'd20, 8'd30, 8'd3, 1'b1);
		send_tap(7'd100, 8'd255, 8'd255, 8'd255, 8'd77, 1'b1);
	endtask

	task automatic test_last_on_write();
		send_tap(7'd80, 8'd5, 8'd6, 8'd7, 8'd0, 1'b0);
		write_coef(7'd3, 24'sh020000, 1'b1);
		send_tap(7'd3, 8'd3, 8'd2, 8'd1, 8'd255, 1'b1);
	endtask

	function automatic logic signed [COEF_W-1:0] rand_coef(int k);
		int span;
		int v;
		if ($urandom_range(3) == 0)
			return COEF_W'($urandom);
		span = 131072 / k;
		v = int'($urandom_range(3 * span)) - span;
		return v[COEF_W-1:0];
	endfunction

	function automatic int pick_size();
		case ($urandom_range(15))
			0: return 81;
			1, 2: return 49;
			3, 4: return 25;
			5, 6, 7, 8: return 9;
			9, 10, 11: return 4;
			12: return $urandom_range(1, N_TAPS);
			default: return 1;
		endcase
	endfunction

	// One well-formed window: optional kernel load, then k taps in raster order
	task automatic run_window(input int k);
		bit reload;
		logic [PIX_W-1:0] a;
		reload = ($urandom_range(2) != 0);
		for (int i = 0; i < k; i++)
			if (reload || !coef_written[i])
				write_coef(i[6:0], rand_coef(k), 1'b0);
		a = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		for (int i = 0; i < k; i++)
			send_tap(i[6:0], PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
				a, i == k - 1);
		windows_run++;
	endtask

	task automatic noise_item();
		int idx;
		case ($urandom_range(3))
			0: write_coef(7'($urandom_range(N_TAPS, 127)), COEF_W'($urandom),
				1'($urandom_range(1)));
			1: send_tap(7'($urandom_range(N_TAPS, 127)), PIX_W'($urandom),
				PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
				$urandom_range(3) == 0);
			2: write_coef(7'($urandom_range(N_TAPS - 1)), rand_coef(9), 1'b1);
			default: begin
				idx = $urandom_range(N_TAPS - 1);
				if (!coef_written[idx])
					idx = 0;
				send_tap(idx[6:0], PIX_W'($urandom), PIX_W'($urandom),
					PIX_W'($urandom), PIX_W'($urandom), $urandom_range(3) == 0);
			end
		endcase
	endtask

	task automatic test_random(input int send_pct, input int recv_pct, input int n_items);
		int start;
		bit paused;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		start = items_sent;
		paused = 0;
		while (items_sent - start < n_items) begin
			if ($urandom_range(99) < 80)
				run_window(pick_size());
			else
				noise_item();
			if (!paused && items_sent - start > n_items / 2) begin
				hold_until_drained();
				paused = 1;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_kernel_extremes();
		test_clamp_boundary();
		test_zero_alpha();
		test_out_of_range();
		test_last_on_write();

		test_random(0, 0, 470);
		test_random(86, 0, 450);
		test_random(0, 86, 450);
		test_random(9, 9, 460);

		@(negedge clk);
		in_valid <= 1'b0;
		recv_stall_pct = 0;
		while (pix_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d transactions in %0d random windows plus directed cases,",
			items_sent, windows_run);
		$display("%0d output pixels checked across four handshake pressure phases.",
			pixels_checked);
		if (errors == 0 && pix_expected.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
